/* hw/rtl/larng_pkg.sv */
`timescale 1ns / 1ps
// Package for the lagged additive generator: word width, mixer and seed
// constants, command codes, fixup base position. No dependencies.
package larng_pkg;

  localparam int unsigned WORD_W = 32;

  typedef logic [WORD_W-1:0] word_t;

  localparam word_t MIXER_A_RESET = 32'h5c25_82a4;
  localparam word_t MIXER_B_RESET = 32'h64df_f8ca;
  localparam word_t SEED_XOR_A    = 32'hA5B9_6384;
  localparam word_t SEED_XOR_B    = 32'h56F0_4021;
  localparam word_t MIX_A_INC     = 32'd1;
  localparam word_t MIX_B_INC     = 32'd13;

  // command codes on in_op
  localparam logic OP_RESEED = 1'b0;
  localparam logic OP_DRAW   = 1'b1;

  // number of forced entries and the first forced position
  localparam int unsigned FIXUP_COUNT = 32;
  localparam int unsigned FIXUP_BASE  = 3;

  // first half of the mixer step: ((a*13 + 1) ^ (a >> 9)) + b
  function automatic word_t mix_a_next(input word_t a, input word_t b);
    word_t a13;
    a13 = (a << 3) + (a << 2) + a;
    return ((a13 + MIX_A_INC) ^ (a >> 9)) + b;
  endfunction

endpackage

/* hw/rtl/lagged_additive_rng_with_seeding.sv */
`timescale 1ns / 1ps
// Top level of the lagged additive generator: table memory, mixer and the
// sequencer for draw and reseed. Depends on larng_pkg.
//
//  channel | direction | ports                        | beat
//  in      | input     | in_op, in_seed               | one command (draw or reseed)
//  out     | output    | out_random_word              | one word per draw
//
// In a draw both table reads issue on the accepting edge; ST_DRAW then adds,
// writes back and loads the output register once the output register is free.
// A reseed passes through the accepting cycle, two states per table entry for
// the mixer (ST_FILL_A, ST_FILL_B), then a read and a write per forced entry.
// Synchronous active-low reset clears control and presets mixer state; the table is
// undefined until the first reseed. A draw waits in place while the output is full.
module lagged_additive_rng_with_seeding #(
  parameter int unsigned TABLE_DEPTH      = 250,
  parameter int unsigned SHORT_LAG_OFFSET = 103,
  parameter int unsigned FIXUP_STRIDE     = 7
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_op,
  input  logic signed [31:0]   in_seed,
  output logic                 out_valid,
  input  logic                 out_ready,
  output larng_pkg::word_t     out_random_word
);
  import larng_pkg::*;

  localparam int unsigned IDX_W   = $clog2(TABLE_DEPTH);
  localparam int unsigned LAG_MOD = SHORT_LAG_OFFSET % TABLE_DEPTH;
  localparam int unsigned FIX_W   = $clog2(FIXUP_COUNT);

  localparam logic [IDX_W:0]   DEPTH_X  = (IDX_W+1)'(TABLE_DEPTH);
  localparam logic [IDX_W:0]   LAG_X    = (IDX_W+1)'(LAG_MOD);
  localparam logic [IDX_W:0]   STRIDE_X = (IDX_W+1)'(FIXUP_STRIDE);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);
  localparam logic [IDX_W-1:0] FIX_POS0 = IDX_W'(FIXUP_BASE % TABLE_DEPTH);
  localparam logic [FIX_W-1:0] FIX_LAST = FIX_W'(FIXUP_COUNT - 1);

  // sequencer states
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_DRAW   = 3'd1;
  localparam logic [2:0] ST_FILL_A = 3'd2;
  localparam logic [2:0] ST_FILL_B = 3'd3;
  localparam logic [2:0] ST_FIX_RD = 3'd4;
  localparam logic [2:0] ST_FIX_WR = 3'd5;

  logic [2:0]       state_r, state_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [IDX_W-1:0] cnt_r, cnt_nxt;
  logic [IDX_W-1:0] pos_r, pos_nxt;
  logic [FIX_W-1:0] fe_r, fe_nxt;
  word_t            mix_a_r, mix_a_nxt;
  word_t            mix_b_r, mix_b_nxt;
  logic             out_valid_r, out_valid_nxt;
  word_t            out_word_r, out_word_nxt;

  // table memory: one write port, two registered read ports
  word_t            table_mem [TABLE_DEPTH];
  word_t            rd_a_r, rd_b_r;
  logic             rd_a_en, rd_b_en;
  logic [IDX_W-1:0] rd_a_addr, rd_b_addr;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  word_t            wr_data;

  logic             in_fire;
  logic [IDX_W:0]   idx_inc, ahead_sum, pos_sum;
  logic [IDX_W-1:0] idx_adv, ahead_idx, pos_adv;
  word_t            fix_mask, fix_bit;

  assign in_ready        = (state_r == ST_IDLE);
  assign in_fire         = in_valid && in_ready;
  assign out_valid       = out_valid_r;
  assign out_random_word = out_word_r;

  // next index and the lagged partner, both wrapped at the table depth
  always_comb begin
    idx_inc   = {1'b0, idx_r} + 1'b1;
    idx_adv   = (idx_inc >= DEPTH_X) ? '0 : idx_inc[IDX_W-1:0];
    ahead_sum = {1'b0, idx_adv} + LAG_X;
    ahead_idx = (ahead_sum >= DEPTH_X) ? IDX_W'(ahead_sum - DEPTH_X)
                                       : ahead_sum[IDX_W-1:0];
    pos_sum   = {1'b0, pos_r} + STRIDE_X;
    pos_adv   = (pos_sum >= DEPTH_X) ? IDX_W'(pos_sum - DEPTH_X)
                                     : pos_sum[IDX_W-1:0];
    fix_mask  = {WORD_W{1'b1}} >> fe_r;
    fix_bit   = {1'b1, {(WORD_W-1){1'b0}}} >> fe_r;
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    cnt_nxt       = cnt_r;
    pos_nxt       = pos_r;
    fe_nxt        = fe_r;
    mix_a_nxt     = mix_a_r;
    mix_b_nxt     = mix_b_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_word_nxt  = out_word_r;
    rd_a_en       = 1'b0;
    rd_b_en       = 1'b0;
    rd_a_addr     = idx_adv;
    rd_b_addr     = ahead_idx;
    wr_en         = 1'b0;
    wr_addr       = cnt_r;
    wr_data       = mix_a_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_op == OP_DRAW) begin
            rd_a_en   = 1'b1;
            rd_b_en   = 1'b1;
            idx_nxt   = idx_adv;
            state_nxt = ST_DRAW;
          end else begin
            mix_a_nxt = ($unsigned(in_seed) - 32'd1) ^ SEED_XOR_A;
            mix_b_nxt = ($unsigned(in_seed) + 32'd1) ^ SEED_XOR_B;
            idx_nxt   = '0;
            cnt_nxt   = '0;
            state_nxt = ST_FILL_A;
          end
        end
      end
      ST_DRAW: begin
        // hold until the output register is free
        if (!out_valid_r || out_ready) begin
          wr_en         = 1'b1;
          wr_addr       = idx_r;
          wr_data       = rd_a_r + rd_b_r;
          out_valid_nxt = 1'b1;
          out_word_nxt  = rd_a_r + rd_b_r;
          state_nxt     = ST_IDLE;
        end
      end
      ST_FILL_A: begin
        mix_a_nxt = mix_a_next(mix_a_r, mix_b_r);
        wr_en     = 1'b1;
        wr_addr   = cnt_r;
        wr_data   = mix_a_nxt;
        state_nxt = ST_FILL_B;
      end
      ST_FILL_B: begin
        mix_b_nxt = (mix_b_r * mix_a_r + MIX_B_INC) ^ (mix_b_r >> 13);
        if (cnt_r == LAST_IDX) begin
          pos_nxt   = FIX_POS0;
          fe_nxt    = '0;
          state_nxt = ST_FIX_RD;
        end else begin
          cnt_nxt   = cnt_r + 1'b1;
          state_nxt = ST_FILL_A;
        end
      end
      ST_FIX_RD: begin
        rd_a_en   = 1'b1;
        rd_a_addr = pos_r;
        state_nxt = ST_FIX_WR;
      end
      ST_FIX_WR: begin
        // clear the bits above the forced leading bit, then set it
        wr_en   = 1'b1;
        wr_addr = pos_r;
        wr_data = (rd_a_r & fix_mask) | fix_bit;
        pos_nxt = pos_adv;
        fe_nxt  = fe_r + 1'b1;
        if (fe_r == FIX_LAST) begin
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_FIX_RD;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control and mixer registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      cnt_r       <= '0;
      pos_r       <= '0;
      fe_r        <= '0;
      mix_a_r     <= MIXER_A_RESET;
      mix_b_r     <= MIXER_B_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      cnt_r       <= cnt_nxt;
      pos_r       <= pos_nxt;
      fe_r        <= fe_nxt;
      mix_a_r     <= mix_a_nxt;
      mix_b_r     <= mix_b_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    out_word_r <= out_word_nxt;
  end

  // table memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      table_mem[wr_addr] <= wr_data;
    end
    if (rd_a_en) begin
      rd_a_r <= table_mem[rd_a_addr];
    end
    if (rd_b_en) begin
      rd_b_r <= table_mem[rd_b_addr];
    end
  end

endmodule
